// ===== sv/shtlp_pkg.sv =====
package shtlp_pkg;

   localparam int TABLE_SLOTS = 256;
   localparam int KEY_BYTES = 16;
   localparam int SLOT_W = $clog2(TABLE_SLOTS);
   localparam int KIDX_W = $clog2(KEY_BYTES);
   localparam int KLEN_W = $clog2(KEY_BYTES + 1);
   localparam int CNT_W = 9;
   localparam int QDEPTH = 2;
   localparam int QIDX_W = 1;
   localparam logic [31:0] HASH_SEED = 32'd5381;
   localparam int HASH_SHIFT = 5;

   localparam logic CMD_PUT = 1'b0;
   localparam logic CMD_GET = 1'b1;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_TOO_LONG = 2'd3;

   // one finished key handed from front to back
   typedef struct packed {
      logic command;
      logic too_long;
      logic [KLEN_W-1:0] key_length;
      logic [SLOT_W-1:0] start;
      logic [31:0] put_value;
      logic [KEY_BYTES*8-1:0] key;
   } op_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_CHECK,
      BK_RESULT
   } back_state_type;

endpackage

// ===== sv/shtlp_front.sv =====
module shtlp_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_command,
   input  logic [7:0] req_key_byte,
   input  logic req_last,
   input  logic signed [31:0] req_put_value,
   output logic op_valid,
   input  logic op_ready,
   output shtlp_pkg::op_type op_data
);

   logic [31:0] hash_ff, hash_in;
   logic [shtlp_pkg::KLEN_W-1:0] len_ff, len_in;
   logic [shtlp_pkg::KEY_BYTES*8-1:0] key_ff, key_in;
   logic [31:0] hash_next;
   logic accept;
   shtlp_pkg::op_type q_ff [shtlp_pkg::QDEPTH];
   logic [shtlp_pkg::QIDX_W-1:0] wr_ff, rd_ff;
   logic [shtlp_pkg::QIDX_W:0] cnt_ff;
   logic push, pop;
   shtlp_pkg::op_type new_op;

   assign req_ready = (cnt_ff < (shtlp_pkg::QIDX_W+1)'(shtlp_pkg::QDEPTH));
   assign accept = req_valid && req_ready;
   assign hash_next = (hash_ff << shtlp_pkg::HASH_SHIFT) + hash_ff + {24'd0, req_key_byte};

   // key buffer and hash accumulation
   always_comb begin
      key_in = key_ff;
      if (len_ff < shtlp_pkg::KLEN_W'(shtlp_pkg::KEY_BYTES - 1))
         key_in[len_ff[shtlp_pkg::KIDX_W-1:0]*8 +: 8] = req_key_byte;
      len_in = len_ff;
      if (len_ff < shtlp_pkg::KLEN_W'(shtlp_pkg::KEY_BYTES))
         len_in = len_ff + 1'b1;
      hash_in = hash_next;
   end

   // operation record built on the last byte
   always_comb begin
      new_op.command = req_command;
      new_op.too_long = (len_in > shtlp_pkg::KLEN_W'(shtlp_pkg::KEY_BYTES - 1));
      new_op.key_length = len_in;
      new_op.start = hash_next[shtlp_pkg::SLOT_W-1:0];
      new_op.put_value = req_put_value;
      new_op.key = key_in;
   end

   assign push = accept && req_last;
   assign pop = op_valid && op_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= shtlp_pkg::HASH_SEED;
         len_ff <= '0;
      end else if (accept) begin
         if (req_last) begin
            hash_ff <= shtlp_pkg::HASH_SEED;
            len_ff <= '0;
         end else begin
            hash_ff <= hash_in;
            len_ff <= len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) key_ff <= key_in;
   end

   // queue toward the back end
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (shtlp_pkg::QIDX_W+1)'(push) - (shtlp_pkg::QIDX_W+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= new_op;
   end

   assign op_valid = (cnt_ff != '0);
   assign op_data = q_ff[rd_ff];

endmodule

// ===== sv/shtlp_back.sv =====
module shtlp_back (
   input  logic clock,
   input  logic reset,
   input  logic op_valid,
   output logic op_ready,
   input  shtlp_pkg::op_type op_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [1:0] rsp_status,
   output logic signed [31:0] rsp_found_value,
   output logic [8:0] rsp_entry_count
);

   localparam int SW = shtlp_pkg::SLOT_W;

   shtlp_pkg::back_state_type state_ff, state_in;
   shtlp_pkg::op_type op_ff;
   logic [SW-1:0] pos_ff, pos_in;
   logic [SW:0] tries_ff, tries_in;
   logic [shtlp_pkg::CNT_W-1:0] count_ff;
   logic [shtlp_pkg::TABLE_SLOTS-1:0] occ_ff;

   // slot memories
   logic [shtlp_pkg::KEY_BYTES*8-1:0] key_mem [shtlp_pkg::TABLE_SLOTS];
   logic [shtlp_pkg::KLEN_W-1:0] klen_mem [shtlp_pkg::TABLE_SLOTS];
   logic [31:0] val_mem [shtlp_pkg::TABLE_SLOTS];
   logic [shtlp_pkg::KEY_BYTES*8-1:0] rkey_ff;
   logic [shtlp_pkg::KLEN_W-1:0] rklen_ff;
   logic [31:0] rval_ff;
   logic rocc_ff;

   logic [1:0] status_ff, status_in;
   logic [31:0] found_ff, found_in;
   logic key_eq, do_write, take;
   logic [shtlp_pkg::KEY_BYTES*8-1:0] mask;

   assign take = op_valid && op_ready;

   // masked key compare over the stored length
   always_comb begin
      for (int b = 0; b < shtlp_pkg::KEY_BYTES; b++)
         mask[b*8 +: 8] = (shtlp_pkg::KLEN_W'(b) < op_ff.key_length) ? 8'hff : 8'h00;
      key_eq = (rklen_ff == op_ff.key_length) && (((rkey_ff ^ op_ff.key) & mask) == '0);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         shtlp_pkg::BK_IDLE: if (take) state_in = op_data.too_long ?
            shtlp_pkg::BK_RESULT : shtlp_pkg::BK_READ;
         shtlp_pkg::BK_READ: state_in = shtlp_pkg::BK_CHECK;
         shtlp_pkg::BK_CHECK:
            if (!rocc_ff || key_eq || tries_ff == (SW+1)'(shtlp_pkg::TABLE_SLOTS - 1))
               state_in = shtlp_pkg::BK_RESULT;
            else state_in = shtlp_pkg::BK_READ;
         shtlp_pkg::BK_RESULT: if (rsp_ready) state_in = shtlp_pkg::BK_IDLE;
         default: state_in = shtlp_pkg::BK_IDLE;
      endcase
   end

   // outputs and probe bookkeeping
   always_comb begin
      op_ready = (state_ff == shtlp_pkg::BK_IDLE);
      rsp_valid = (state_ff == shtlp_pkg::BK_RESULT);
      pos_in = pos_ff;
      tries_in = tries_ff;
      status_in = status_ff;
      found_in = found_ff;
      do_write = 1'b0;
      case (state_ff)
         shtlp_pkg::BK_IDLE: begin
            pos_in = op_data.start;
            tries_in = '0;
            found_in = '0;
            status_in = op_data.too_long ? shtlp_pkg::ST_TOO_LONG :
               (op_data.command == shtlp_pkg::CMD_PUT ? shtlp_pkg::ST_FULL :
               shtlp_pkg::ST_NOT_FOUND);
         end
         shtlp_pkg::BK_CHECK: begin
            if (!rocc_ff) begin
               if (op_ff.command == shtlp_pkg::CMD_PUT) begin
                  do_write = 1'b1;
                  status_in = shtlp_pkg::ST_OK;
               end else status_in = shtlp_pkg::ST_NOT_FOUND;
            end else if (key_eq) begin
               status_in = shtlp_pkg::ST_OK;
               if (op_ff.command == shtlp_pkg::CMD_PUT) do_write = 1'b1;
               else found_in = rval_ff;
            end else begin
               pos_in = pos_ff + 1'b1;
               tries_in = tries_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= shtlp_pkg::BK_IDLE;
         occ_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (do_write && !rocc_ff) begin
            occ_ff[pos_ff] <= 1'b1;
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) op_ff <= op_data;
      pos_ff <= pos_in;
      tries_ff <= tries_in;
      status_ff <= status_in;
      found_ff <= found_in;
   end

   // memory read and write ports
   always_ff @(posedge clock) begin
      rkey_ff <= key_mem[pos_ff];
      rklen_ff <= klen_mem[pos_ff];
      rval_ff <= val_mem[pos_ff];
      rocc_ff <= occ_ff[pos_ff];
      if (do_write) begin
         key_mem[pos_ff] <= op_ff.key;
         klen_mem[pos_ff] <= op_ff.key_length;
         val_mem[pos_ff] <= op_ff.put_value;
      end
   end

   assign rsp_status = status_ff;
   assign rsp_found_value = found_ff;
   assign rsp_entry_count = count_ff;

endmodule

// ===== sv/string_hash_table_linear_probe.sv =====
// bytes that are not last give no response; the response to a last byte
// can be taken after its probes, each a slot read then a key compare,
// probes from 0 (key too long) to TABLE_SLOTS
// throughput: one byte per cycle at the front while its queue has room; the back
// end's probe loop (BK_READ slot read, BK_CHECK compare) sets the operation rate
// reset: synchronous, clears occupancy, count, hash and the queue; no clearing pass
module string_hash_table_linear_probe (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_command,
   input  logic [7:0] req_key_byte,
   input  logic req_last,
   input  logic signed [31:0] req_put_value,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [1:0] rsp_status,
   output logic signed [31:0] rsp_found_value,
   output logic [8:0] rsp_entry_count
);

   logic op_valid, op_ready;
   shtlp_pkg::op_type op_data;

   shtlp_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_command, .req_key_byte,
      .req_last, .req_put_value, .op_valid, .op_ready, .op_data
   );

   shtlp_back u_back (
      .clock, .reset, .op_valid, .op_ready, .op_data, .rsp_valid, .rsp_ready,
      .rsp_status, .rsp_found_value, .rsp_entry_count
   );

endmodule

// ===== verif/string_hash_table_linear_probe_tb.sv =====
`timescale 1ns / 1ps

module string_hash_table_linear_probe_tb;

   typedef struct {
      logic command;
      logic [7:0] key_byte;
      logic last;
      logic [31:0] put_value;
   } key_req_type;

   typedef struct {
      logic [1:0] status;
      logic [31:0] found_value;
      logic [8:0] entry_count;
   } lookup_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_command = 1'b0;
   logic [7:0] req_key_byte = 8'd0;
   logic req_last = 1'b0;
   logic signed [31:0] req_put_value = 32'sd0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic signed [31:0] rsp_found_value;
   logic [8:0] rsp_entry_count;

   string_hash_table_linear_probe u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_key_byte(req_key_byte),
      .req_last(req_last),
      .req_put_value(req_put_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_found_value(rsp_found_value),
      .rsp_entry_count(rsp_entry_count)
   );

   always #5 clock = ~clock;

   // shadow copy of the table
   logic [7:0] tbl_key [shtlp_pkg::TABLE_SLOTS][shtlp_pkg::KEY_BYTES];
   logic [31:0] tbl_value [shtlp_pkg::TABLE_SLOTS];
   logic tbl_used [shtlp_pkg::TABLE_SLOTS];
   int tbl_key_len [shtlp_pkg::TABLE_SLOTS];
   int tbl_count;
   logic [7:0] cur_key [shtlp_pkg::KEY_BYTES];
   int cur_len;
   logic [31:0] cur_hash;

   key_req_type pending_reqs[$];
   lookup_rsp_type expected_rsps[$];
   int mismatches = 0;
   bit stimulus_done = 0;
   int sent_count = 0;

   // known keys for later gets and overwrites
   logic [7:0] known_keys [$][$];

   function automatic bit slot_matches(int p);
      if (tbl_key_len[p] != cur_len) return 0;
      for (int i = 0; i < cur_len; i++)
         if (tbl_key[p][i] != cur_key[i]) return 0;
      return 1;
   endfunction

   // fold one request into the shadow table, queue the response on a last byte
   function automatic void predict_lookup(key_req_type r);
      lookup_rsp_type e;
      int start;
      int p;
      cur_hash = (cur_hash << shtlp_pkg::HASH_SHIFT) + cur_hash + {24'd0, r.key_byte};
      if (cur_len < shtlp_pkg::KEY_BYTES - 1) cur_key[cur_len] = r.key_byte;
      if (cur_len < shtlp_pkg::KEY_BYTES) cur_len++;
      if (!r.last) return;
      e.found_value = 32'd0;
      if (cur_len > shtlp_pkg::KEY_BYTES - 1) begin
         e.status = shtlp_pkg::ST_TOO_LONG;
      end else begin
         start = cur_hash % shtlp_pkg::TABLE_SLOTS;
         e.status = (r.command == shtlp_pkg::CMD_PUT) ? shtlp_pkg::ST_FULL :
                    shtlp_pkg::ST_NOT_FOUND;
         for (int i = 0; i < shtlp_pkg::TABLE_SLOTS; i++) begin
            p = (start + i) % shtlp_pkg::TABLE_SLOTS;
            if (!tbl_used[p]) begin
               if (r.command == shtlp_pkg::CMD_PUT) begin
                  for (int k = 0; k < cur_len; k++) tbl_key[p][k] = cur_key[k];
                  tbl_key_len[p] = cur_len;
                  tbl_value[p] = r.put_value;
                  tbl_used[p] = 1;
                  tbl_count++;
                  e.status = shtlp_pkg::ST_OK;
               end else begin
                  e.status = shtlp_pkg::ST_NOT_FOUND;
               end
               break;
            end
            if (slot_matches(p)) begin
               if (r.command == shtlp_pkg::CMD_PUT) tbl_value[p] = r.put_value;
               else e.found_value = tbl_value[p];
               e.status = shtlp_pkg::ST_OK;
               break;
            end
         end
      end
      e.entry_count = tbl_count[8:0];
      cur_len = 0;
      cur_hash = shtlp_pkg::HASH_SEED;
      expected_rsps.push_back(e);
   endfunction

   // queue one whole key as a sequence of byte requests
   task automatic push_key(logic cmd, logic [7:0] bytes[$], logic [31:0] val);
      key_req_type r;
      for (int i = 0; i < bytes.size(); i++) begin
         r.command = cmd;
         r.key_byte = bytes[i];
         r.last = (i == bytes.size() - 1);
         r.put_value = r.last ? val : $urandom;
         pending_reqs.push_back(r);
      end
   endtask

   function automatic int gap_len();
      int s;
      s = $urandom_range(0, 99);
      if (s < 50) return 0;
      if (s < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver
   int drv_gap = 0;
   key_req_type drv_item;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            predict_lookup(drv_item);
            sent_count++;
         end
         if (drv_gap > 0) begin
            drv_gap--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            drv_item = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_command <= drv_item.command;
            req_key_byte <= drv_item.key_byte;
            req_last <= drv_item.last;
            req_put_value <= drv_item.put_value;
            drv_gap = gap_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor and response stalls
   int stall = 0;
   lookup_rsp_type exp_rsp;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response status=%0d value=%0d count=%0d",
                           rsp_status, rsp_found_value, rsp_entry_count);
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_status !== exp_rsp.status
                   || rsp_found_value !== exp_rsp.found_value
                   || rsp_entry_count !== exp_rsp.entry_count) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"response mismatch: exp status=%0d value=%0d count=%0d,",
                               " got status=%0d value=%0d count=%0d"},
                              exp_rsp.status, $signed(exp_rsp.found_value),
                              exp_rsp.entry_count, rsp_status, rsp_found_value,
                              rsp_entry_count);
               end
            end
         end
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            stall = gap_len();
         end
      end
   end

   // random key, short lengths mostly so hashes and probes collide
   function automatic void rand_key(output logic [7:0] k[$], input int len);
      k = {};
      for (int i = 0; i < len; i++) k.push_back($urandom_range(1, 255));
   endfunction

   initial begin
      logic [7:0] k[$];
      logic [7:0] kk[$];
      int pick;
      int len;
      for (int i = 0; i < shtlp_pkg::TABLE_SLOTS; i++) tbl_used[i] = 0;
      tbl_count = 0;
      cur_len = 0;
      cur_hash = shtlp_pkg::HASH_SEED;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: get on empty, put, get, overwrite, extremes, too long, zero byte
      k = {8'h01};
      push_key(shtlp_pkg::CMD_GET, k, 32'd0);
      push_key(shtlp_pkg::CMD_PUT, k, 32'h7fffffff);
      push_key(shtlp_pkg::CMD_GET, k, 32'd0);
      push_key(shtlp_pkg::CMD_PUT, k, 32'h80000000);
      push_key(shtlp_pkg::CMD_GET, k, 32'd0);
      k = {8'hff, 8'h00, 8'h55};
      push_key(shtlp_pkg::CMD_PUT, k, 32'hffffffff);
      push_key(shtlp_pkg::CMD_GET, k, 32'd0);
      k = {};
      for (int i = 0; i < shtlp_pkg::KEY_BYTES - 1; i++) k.push_back(8'haa);
      push_key(shtlp_pkg::CMD_PUT, k, 32'd0);
      push_key(shtlp_pkg::CMD_GET, k, 32'd0);
      k.push_back(8'h01);
      push_key(shtlp_pkg::CMD_PUT, k, 32'd5);
      k.push_back(8'h02);
      k.push_back(8'h03);
      push_key(shtlp_pkg::CMD_GET, k, 32'd0);

      // random phase: random puts of new keys, mixed gets and overwrites
      while (pending_reqs.size() + sent_count < 1400) begin
         pick = $urandom_range(0, 99);
         if (pick < 45 || known_keys.size() == 0) begin
            len = ($urandom_range(0, 19) == 0) ?
                  $urandom_range(1, shtlp_pkg::KEY_BYTES + 2) : $urandom_range(1, 3);
            rand_key(k, len);
            if ($urandom_range(0, 9) == 0) k[$urandom_range(0, len - 1)] = 8'h00;
            if (len < shtlp_pkg::KEY_BYTES) known_keys.push_back(k);
            push_key($urandom_range(0, 3) == 0 ? shtlp_pkg::CMD_GET : shtlp_pkg::CMD_PUT,
                     k, $urandom);
         end else begin
            kk = known_keys[$urandom_range(0, known_keys.size() - 1)];
            push_key(pick < 80 ? shtlp_pkg::CMD_GET : shtlp_pkg::CMD_PUT, kk, $urandom);
         end
         if (pending_reqs.size() > 64) wait (pending_reqs.size() < 16);
      end
      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_rsps.size() == 0);
      repeat (1200) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
